### src/tcp_header_filter_and_stats_assert.svh
// assertion macros shared by the rtl
`ifndef TCP_HEADER_FILTER_AND_STATS_ASSERT_SVH
`define TCP_HEADER_FILTER_AND_STATS_ASSERT_SVH

// same-cycle implication, off during reset
`define TCPHF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcphf assertion failed");

// next-cycle implication, off during reset
`define TCPHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcphf assertion failed");

`endif

### src/tcphf_pkg.sv
package tcphf_pkg;

  localparam int ADDR_DEPTH = 128;
  localparam int CNT_W      = $clog2(ADDR_DEPTH + 1);
  localparam int NUM_FLAGS  = 6;
  localparam int PADDR_W    = 5;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    VERD_BAD_LEN  = 3'd0,
    VERD_NOT_TCP  = 3'd1,
    VERD_FILTERED = 3'd2,
    VERD_RECORDED = 3'd3,
    VERD_FULL     = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    REG_SRC_IP   = 3'd0,
    REG_DST_IP   = 3'd1,
    REG_SRC_PORT = 3'd2,
    REG_DST_PORT = 3'd3,
    REG_MIN_LEN  = 3'd4,
    REG_MAX_LEN  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } addr_pair_t;

  // lookup token walking the cell row
  typedef struct packed {
    logic        vld;
    logic        src_found;
    logic        dst_found;
    logic [31:0] src_hits;
    logic [31:0] dst_hits;
  } token_t;

  // append command broadcast to the row
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] slot;
  } append_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

### src/tcphf_if.sv
interface tcphf_hdr_if;
  logic        valid;
  logic        ready;
  logic [11:0] frame_length;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [7:0]  tcp_flags;

  modport source (output valid, frame_length, ether_type, ip_protocol, src_ip, dst_ip,
                  sport, dport, tcp_flags, input ready);
  modport sink (input valid, frame_length, ether_type, ip_protocol, src_ip, dst_ip,
                sport, dport, tcp_flags, output ready);
endinterface

interface tcphf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  entry_count;
  logic [31:0] src_hits;
  logic [31:0] dst_hits;
  logic [31:0] packet_total;
  logic [31:0] tcp_total;
  logic [31:0] fin_total;
  logic [31:0] syn_total;
  logic [31:0] rst_total;
  logic [31:0] push_total;
  logic [31:0] ack_total;
  logic [31:0] urg_total;

  modport source (output valid, verdict, entry_count, src_hits, dst_hits, packet_total,
                  tcp_total, fin_total, syn_total, rst_total, push_total, ack_total,
                  urg_total, input ready);
  modport sink (input valid, verdict, entry_count, src_hits, dst_hits, packet_total,
                tcp_total, fin_total, syn_total, rst_total, push_total, ack_total,
                urg_total, output ready);
endinterface

### src/tcphf_cell.sv
module tcphf_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tcphf_pkg::CNT_W-1:0]   my_slot,
  input  logic [tcphf_pkg::CNT_W-1:0]   used,
  input  tcphf_pkg::addr_pair_t         key,
  input  tcphf_pkg::append_t            app,
  input  tcphf_pkg::token_t             tok_in,
  output tcphf_pkg::token_t             tok_out
);

  logic [31:0] ent_src;
  logic [31:0] ent_dst;
  logic [31:0] src_hits;
  logic [31:0] dst_hits;
  logic        live;
  logic        src_hit_now;
  logic        dst_hit_now;

  assign live        = (my_slot < used);
  assign src_hit_now = tok_in.vld && live && !tok_in.src_found && (ent_src == key.src);
  assign dst_hit_now = tok_in.vld && live && !tok_in.dst_found && (ent_dst == key.dst);

  // entry storage, written by append or by a hit
  always_ff @(posedge clk) begin
    if (app.en && (app.slot == my_slot)) begin
      ent_src  <= key.src;
      ent_dst  <= key.dst;
      src_hits <= 32'd1;
      dst_hits <= 32'd1;
    end else begin
      if (src_hit_now) src_hits <= tcphf_pkg::sat_inc(src_hits);
      if (dst_hit_now) dst_hits <= tcphf_pkg::sat_inc(dst_hits);
    end
  end

  // token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.src_found <= tok_in.src_found || src_hit_now;
    tok_out.dst_found <= tok_in.dst_found || dst_hit_now;
    tok_out.src_hits  <= src_hit_now ? tcphf_pkg::sat_inc(src_hits) : tok_in.src_hits;
    tok_out.dst_hits  <= dst_hit_now ? tcphf_pkg::sat_inc(dst_hits) : tok_in.dst_hits;
  end

endmodule

### src/tcp_header_filter_and_stats.sv
// channel   dir  handshake        payload
// hdr       in   valid/ready      parsed ethernet/ipv4/tcp header fields
// res       out  valid/ready      verdict, table count, hits, running totals
// apb       in   psel/penable     six match and length registers, 4-byte stride
//
// one transaction at a time; a rejected, non-tcp or filtered header skips the scan state
// a recorded header also waits in the scan state while the lookup token
//   walks the cell row one cell per cycle
// rst is synchronous; it empties the table count and zeroes all totals
// the result sits in an output register, so a stalled res only blocks the next
//   header once the next result is ready to be written
`include "tcp_header_filter_and_stats_assert.svh"

module tcp_header_filter_and_stats (
  input  logic                              clk,
  input  logic                              rst,
  tcphf_hdr_if.sink                         hdr,
  tcphf_res_if.source                       res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcphf_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int D = tcphf_pkg::ADDR_DEPTH;
  localparam int W = tcphf_pkg::CNT_W;

  // configuration registers
  logic [31:0] src_ip_match;
  logic [31:0] dst_ip_match;
  logic [15:0] sport_match;
  logic [15:0] dport_match;
  logic [11:0] min_frame_length;
  logic [11:0] max_frame_length;

  tcphf_pkg::reg_idx_t reg_sel;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = tcphf_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_ip_match     <= '0;
      dst_ip_match     <= '0;
      sport_match      <= '0;
      dport_match      <= '0;
      min_frame_length <= '0;
      max_frame_length <= 12'd2048;
    end else if (cfg_wr) begin
      case (reg_sel)
        tcphf_pkg::REG_SRC_IP:   src_ip_match     <= pwdata;
        tcphf_pkg::REG_DST_IP:   dst_ip_match     <= pwdata;
        tcphf_pkg::REG_SRC_PORT: sport_match      <= pwdata[15:0];
        tcphf_pkg::REG_DST_PORT: dport_match      <= pwdata[15:0];
        tcphf_pkg::REG_MIN_LEN:  min_frame_length <= pwdata[11:0];
        tcphf_pkg::REG_MAX_LEN:  max_frame_length <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tcphf_pkg::REG_SRC_IP:   prdata = src_ip_match;
      tcphf_pkg::REG_DST_IP:   prdata = dst_ip_match;
      tcphf_pkg::REG_SRC_PORT: prdata = {16'd0, sport_match};
      tcphf_pkg::REG_DST_PORT: prdata = {16'd0, dport_match};
      tcphf_pkg::REG_MIN_LEN:  prdata = {20'd0, min_frame_length};
      tcphf_pkg::REG_MAX_LEN:  prdata = {20'd0, max_frame_length};
      default:                 prdata = '0;
    endcase
  end

  // header classification at accept time
  tcphf_pkg::verdict_t cls_now;
  logic                hdr_take;

  always_comb begin
    if ((hdr.frame_length > max_frame_length) || (hdr.frame_length < min_frame_length)) begin
      cls_now = tcphf_pkg::VERD_BAD_LEN;
    end else if ((hdr.ether_type != tcphf_pkg::ETHERTYPE_IPV4) ||
                 (hdr.ip_protocol != tcphf_pkg::PROTO_TCP)) begin
      cls_now = tcphf_pkg::VERD_NOT_TCP;
    end else if (((src_ip_match != '0) && (hdr.src_ip != src_ip_match)) ||
                 ((dst_ip_match != '0) && (hdr.dst_ip != dst_ip_match)) ||
                 ((sport_match != '0) && (hdr.sport != sport_match)) ||
                 ((dport_match != '0) && (hdr.dport != dport_match))) begin
      cls_now = tcphf_pkg::VERD_FILTERED;
    end else begin
      cls_now = tcphf_pkg::VERD_RECORDED;
    end
  end

  // held transaction
  tcphf_pkg::state_t     state, state_next;
  tcphf_pkg::verdict_t   cls;
  tcphf_pkg::addr_pair_t key;
  logic [5:0]            flags;
  logic                  fin_go;

  assign hdr_take = hdr.valid && hdr.ready;

  always_ff @(posedge clk) begin
    if (hdr_take) begin
      cls       <= cls_now;
      key.src   <= hdr.src_ip;
      key.dst   <= hdr.dst_ip;
      flags     <= hdr.tcp_flags[5:0];
    end
  end

  // cell row: token enters cell 0 the cycle after accept
  tcphf_pkg::token_t  chain [D+1];
  tcphf_pkg::append_t app;
  logic [W-1:0]       used;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= hdr_take && (cls_now == tcphf_pkg::VERD_RECORDED);
    end
    chain[0].src_found <= 1'b0;
    chain[0].dst_found <= 1'b0;
    chain[0].src_hits  <= '0;
    chain[0].dst_hits  <= '0;
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    tcphf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_slot (W'(i)),
      .used    (used),
      .key     (key),
      .app     (app),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // lookup outcome captured from the row end
  logic        any_found;
  logic [31:0] look_src_hits;
  logic [31:0] look_dst_hits;

  always_ff @(posedge clk) begin
    if (chain[D].vld) begin
      any_found     <= chain[D].src_found || chain[D].dst_found;
      look_src_hits <= chain[D].src_hits;
      look_dst_hits <= chain[D].dst_hits;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcphf_pkg::ST_IDLE: begin
        if (hdr_take) begin
          state_next = (cls_now == tcphf_pkg::VERD_RECORDED) ? tcphf_pkg::ST_SCAN
                                                             : tcphf_pkg::ST_FINISH;
        end
      end
      tcphf_pkg::ST_SCAN: begin
        if (chain[D].vld) state_next = tcphf_pkg::ST_FINISH;
      end
      tcphf_pkg::ST_FINISH: begin
        if (fin_go) state_next = tcphf_pkg::ST_IDLE;
      end
      default: state_next = tcphf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcphf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // state outputs
  always_comb begin
    hdr.ready = (state == tcphf_pkg::ST_IDLE);
    fin_go    = (state == tcphf_pkg::ST_FINISH) && (!res.valid || res.ready);
  end

  // result assembly and counter updates
  logic                recorded;
  logic                do_append;
  logic [W-1:0]        used_next;
  tcphf_pkg::verdict_t verdict_fin;
  logic [31:0]         src_hits_fin;
  logic [31:0]         dst_hits_fin;
  logic [31:0]         packet_total, packet_total_next;
  logic [31:0]         tcp_total, tcp_total_next;
  logic [31:0]         flag_total [tcphf_pkg::NUM_FLAGS];
  logic [31:0]         flag_total_next [tcphf_pkg::NUM_FLAGS];

  assign recorded  = (cls == tcphf_pkg::VERD_RECORDED);
  assign do_append = fin_go && recorded && !any_found && (used < W'(D));
  assign used_next = do_append ? used + W'(1) : used;
  assign app.en    = do_append;
  assign app.slot  = used;

  always_comb begin
    verdict_fin  = cls;
    src_hits_fin = '0;
    dst_hits_fin = '0;
    if (recorded) begin
      if (any_found) begin
        src_hits_fin = look_src_hits;
        dst_hits_fin = look_dst_hits;
      end else if (used < W'(D)) begin
        src_hits_fin = 32'd1;
        dst_hits_fin = 32'd1;
      end else begin
        verdict_fin = tcphf_pkg::VERD_FULL;
      end
    end
    packet_total_next = (cls != tcphf_pkg::VERD_BAD_LEN) ?
                        tcphf_pkg::sat_inc(packet_total) : packet_total;
    tcp_total_next    = ((cls == tcphf_pkg::VERD_FILTERED) || recorded) ?
                        tcphf_pkg::sat_inc(tcp_total) : tcp_total;
    for (int k = 0; k < tcphf_pkg::NUM_FLAGS; k++) begin
      flag_total_next[k] = (recorded && flags[k]) ?
                           tcphf_pkg::sat_inc(flag_total[k]) : flag_total[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      packet_total <= '0;
      tcp_total    <= '0;
      for (int k = 0; k < tcphf_pkg::NUM_FLAGS; k++) flag_total[k] <= '0;
    end else if (fin_go) begin
      used         <= used_next;
      packet_total <= packet_total_next;
      tcp_total    <= tcp_total_next;
      for (int k = 0; k < tcphf_pkg::NUM_FLAGS; k++) flag_total[k] <= flag_total_next[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fin_go) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (fin_go) begin
      res.verdict      <= verdict_fin;
      res.entry_count  <= 8'(used_next);
      res.src_hits     <= src_hits_fin;
      res.dst_hits     <= dst_hits_fin;
      res.packet_total <= packet_total_next;
      res.tcp_total    <= tcp_total_next;
      res.fin_total    <= flag_total_next[0];
      res.syn_total    <= flag_total_next[1];
      res.rst_total    <= flag_total_next[2];
      res.push_total   <= flag_total_next[3];
      res.ack_total    <= flag_total_next[4];
      res.urg_total    <= flag_total_next[5];
    end
  end

  // token only leaves the row while a lookup is pending
  `TCPHF_ASSERT_NOW(a_tok_in_scan, chain[D].vld, state == tcphf_pkg::ST_SCAN)
  // table fill never passes the depth
  `TCPHF_ASSERT_NOW(a_used_bound, 1'b1, used <= W'(D))
  // an accepted header always leaves idle
  `TCPHF_ASSERT_NEXT(a_accept_busy, hdr_take, state != tcphf_pkg::ST_IDLE)
  // a full-table verdict only comes with zero hits
  `TCPHF_ASSERT_NOW(a_full_no_hits, res.valid && (res.verdict == tcphf_pkg::VERD_FULL),
                    (res.src_hits == '0) && (res.dst_hits == '0))

endmodule
